### rtl/text_mode_terminal_writer_unit_macros.svh
// Assertion macros shared by the text console writer RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef TEXT_MODE_TERMINAL_WRITER_UNIT_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TMTW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that, when seen, requires a consequence in the same cycle.
`define TMTW_ASSERT_IMP(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

`endif

### rtl/tmtw_pkg.sv
// Package of the text console writer: geometry, widths, codes and the
// command and status bundles between controller and datapath. No dependencies.
package tmtw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 24;
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int KEPT_CELLS = CELLS - COLUMNS;
  localparam int CELL_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);

  localparam int OP_W       = 2;
  localparam int CHAR_W     = 8;
  localparam int ADDR_IN_W  = 11;
  localparam int POS_W      = 11;
  localparam int S_DATA_W   = 24;
  localparam int M_DATA_W   = 32;

  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_SUBST    = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;
  localparam logic [CHAR_W-1:0] ATTR_BLANK  = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    logic load_item;
    logic write_char;
    logic sweep_chars;
    logic sweep_attrs;
    logic scroll;
    logic capture;
    logic home;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic cnt_last;
    logic out_free;
  } stat_t;

endpackage

### rtl/tmtw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tmtw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1920
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tmtw_ctrl.sv
// Controller of the text console writer: sequences reset fill, writes,
// scrolls, clears and reads. Depends on tmtw_pkg.
module tmtw_ctrl
  import tmtw_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  input  stat_t           stat,
  output logic            in_ready,
  output cmd_t            cmd
);

  typedef enum logic [8:0] {
    ST_INIT   = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_WRITE  = 9'b000000100,
    ST_SCROLL = 9'b000001000,
    ST_DRAIN  = 9'b000010000,
    ST_CLEAR  = 9'b000100000,
    ST_READ   = 9'b001000000,
    ST_RCAP   = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  state_t dispatch;
  logic   accept;

  always_comb begin
    case (in_op)
      OP_WRITE: dispatch = ST_WRITE;
      OP_CLEAR: dispatch = ST_CLEAR;
      OP_READ:  dispatch = ST_READ;
      default:  dispatch = ST_DONE;
    endcase
  end

  assign in_ready = (state == ST_IDLE) || ((state == ST_DONE) && stat.out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.load_item = accept;
    state_next    = state;
    case (state)
      ST_INIT: begin
        cmd.sweep_chars = 1'b1;
        cmd.sweep_attrs = 1'b1;
        if (stat.cnt_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = dispatch;
        end
      end
      ST_WRITE: begin
        cmd.write_char = 1'b1;
        state_next     = stat.need_scroll ? ST_SCROLL : ST_DONE;
      end
      ST_SCROLL: begin
        cmd.scroll = 1'b1;
        if (stat.cnt_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_CLEAR: begin
        cmd.sweep_chars = 1'b1;
        cmd.home        = 1'b1;
        if (stat.cnt_last) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        state_next = ST_RCAP;
      end
      ST_RCAP: begin
        cmd.capture = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = accept ? dispatch : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/tmtw_dp.sv
// Datapath of the text console writer: item registers, cursor, sweep counter,
// character and attribute RAMs and the output register.
// Depends on tmtw_pkg, tmtw_ram and the assertion macro header.
`include "text_mode_terminal_writer_unit_macros.svh"

module tmtw_dp
  import tmtw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [OP_W-1:0]     in_op,
  input  logic [CHAR_W-1:0]   in_char,
  input  logic                in_eos,
  input  logic [ADDR_IN_W-1:0] in_addr,
  output logic                m_valid,
  input  logic                m_ready,
  output logic [M_DATA_W-1:0] m_data,
  output logic                m_user
);

  op_t                  op_q;
  logic [CHAR_W-1:0]    ch_q;
  logic                 eos_q;
  logic [ADDR_IN_W-1:0] addr_q;

  logic [COL_W-1:0]     cursor_col;
  logic [ROW_W-1:0]     cursor_row;
  logic [CELL_W-1:0]    cnt;
  logic [CELL_W-1:0]    cur_idx;
  logic                 col_last;
  logic                 row_last;
  logic                 wraps;
  logic                 fill;

  logic                 copy_pend;
  logic                 fill_d;
  logic [CELL_W-1:0]    wr_idx_d;

  logic                 char_we;
  logic [CELL_W-1:0]    char_waddr;
  logic [CHAR_W-1:0]    char_wdata;
  logic                 attr_we;
  logic [CELL_W-1:0]    attr_waddr;
  logic [CHAR_W-1:0]    attr_wdata;
  logic [CELL_W-1:0]    rd_addr;
  logic [CHAR_W-1:0]    char_rdata;
  logic [CHAR_W-1:0]    attr_rdata;
  logic [CHAR_W-1:0]    stored_char;

  logic [CHAR_W-1:0]    rd_char;
  logic [CHAR_W-1:0]    rd_attr;
  logic                 res_update;

  logic                 m_valid_q;
  logic                 m_user_q;
  logic [POS_W-1:0]     m_pos_q;
  logic [CHAR_W-1:0]    m_char_q;
  logic [CHAR_W-1:0]    m_attr_q;

  assign cur_idx  = CELL_W'(cursor_row) * CELL_W'(COLUMNS) + CELL_W'(cursor_col);
  assign col_last = (cursor_col == COL_W'(COLUMNS - 1));
  assign row_last = (cursor_row == ROW_W'(ROWS - 1));
  assign wraps    = (ch_q == CH_NEWLINE) || col_last;
  assign fill     = (cnt >= CELL_W'(KEPT_CELLS));

  assign stat.need_scroll = wraps && row_last;
  assign stat.cnt_last    = (cnt == CELL_W'(CELLS - 1));
  assign stat.out_free    = !m_valid_q || m_ready;

  assign stored_char = (ch_q inside {[CH_PRINT_LO:CH_PRINT_HI]}) ? ch_q : CH_SUBST;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q   <= op_t'(in_op);
      ch_q   <= in_char;
      eos_q  <= in_eos;
      addr_q <= in_addr;
    end
    wr_idx_d <= cnt;
    fill_d   <= fill;
    if (cmd.capture) begin
      if (32'(addr_q) < CELLS) begin
        rd_char <= char_rdata;
        rd_attr <= attr_rdata;
      end else begin
        rd_char <= '0;
        rd_attr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      cnt        <= '0;
      copy_pend  <= 1'b0;
    end else begin
      copy_pend <= cmd.scroll;
      if (cmd.sweep_chars || cmd.sweep_attrs || cmd.scroll) begin
        cnt <= stat.cnt_last ? '0 : cnt + CELL_W'(1);
      end
      if (cmd.home) begin
        cursor_col <= '0;
        cursor_row <= '0;
      end else if (cmd.write_char) begin
        if (wraps) begin
          cursor_col <= '0;
          if (!row_last) begin
            cursor_row <= cursor_row + ROW_W'(1);
          end
        end else begin
          cursor_col <= cursor_col + COL_W'(1);
        end
      end
    end
  end

  always_comb begin
    char_we    = 1'b0;
    char_waddr = cnt;
    char_wdata = CH_SPACE;
    attr_we    = 1'b0;
    attr_waddr = cnt;
    attr_wdata = ATTR_BLANK;
    if (copy_pend) begin
      char_we    = 1'b1;
      char_waddr = wr_idx_d;
      char_wdata = fill_d ? CH_SPACE : char_rdata;
      attr_we    = 1'b1;
      attr_waddr = wr_idx_d;
      attr_wdata = fill_d ? ATTR_BLANK : attr_rdata;
    end else if (cmd.write_char) begin
      char_we    = (ch_q != CH_NEWLINE);
      char_waddr = cur_idx;
      char_wdata = stored_char;
    end else begin
      char_we = cmd.sweep_chars;
      attr_we = cmd.sweep_attrs;
    end
  end

  always_comb begin
    if (cmd.scroll) begin
      rd_addr = fill ? '0 : cnt + CELL_W'(COLUMNS);
    end else begin
      rd_addr = CELL_W'(addr_q);
    end
  end

  tmtw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (char_waddr),
    .wdata (char_wdata),
    .raddr (rd_addr),
    .rdata (char_rdata)
  );

  tmtw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_attr_ram (
    .clk   (clk),
    .we    (attr_we),
    .waddr (attr_waddr),
    .wdata (attr_wdata),
    .raddr (rd_addr),
    .rdata (attr_rdata)
  );

  assign res_update = (op_q == OP_WRITE) && eos_q;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_user_q <= res_update;
      m_pos_q  <= res_update ? POS_W'(cur_idx) : '0;
      m_char_q <= (op_q == OP_READ) ? rd_char : '0;
      m_attr_q <= (op_q == OP_READ) ? rd_attr : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_ready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_valid = m_valid_q;
  assign m_user  = m_user_q;
  assign m_data  = {(M_DATA_W - POS_W - 2 * CHAR_W)'(0), m_attr_q, m_char_q, m_pos_q};

  `TMTW_ASSERT(a_row_range, cursor_row <= ROW_W'(ROWS - 1), "cursor row past last row")
  `TMTW_ASSERT(a_col_range, cursor_col <= COL_W'(COLUMNS - 1), "cursor column past row end")
  `TMTW_ASSERT_IMP(a_copy_after_scroll, copy_pend, $past(cmd.scroll), "copy without scroll read")
  `TMTW_ASSERT_IMP(a_load_when_free, cmd.load_out, !m_valid_q || m_ready, "result overwritten")

endmodule

### rtl/text_mode_terminal_writer_unit.sv
// Text console writer: an 80x24 character and attribute buffer with cursor.
// A write passes through the WRITE and DONE states, a read through READ, RCAP and DONE;
// the result is registered once the output is free, and a new transaction can be taken in
// DONE as it loads. A write that scrolls adds one pass over all 1920 cells and the DRAIN
// state; a clear sweeps the characters of all 1920 cells. Reset: rst is synchronous; then
// a fill of both buffers runs before the first transaction is taken. Each buffer has a single write port.
module text_mode_terminal_writer_unit
  import tmtw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // char_code[7:0], cell_index[18:8], zero pad
  input  logic [OP_W-1:0]     s_axis_tuser,   // op
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,   // cursor_pos[10:0], read_char[18:11],
                                              // read_attr[26:19], zero pad
  output logic                m_axis_tuser    // cursor_update
);

  cmd_t  cmd;
  stat_t stat;

  tmtw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  tmtw_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .in_op   (s_axis_tuser),
    .in_char (s_axis_tdata[CHAR_W-1:0]),
    .in_eos  (s_axis_tlast),
    .in_addr (s_axis_tdata[CHAR_W +: ADDR_IN_W]),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata),
    .m_user  (m_axis_tuser)
  );

endmodule
